// ===== rtl/writeback_slot_nop_inserter_defines.svh =====
// ----------------------------------------------------------------------------
// writeback slot nop inserter: assertion macros
// shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is asserted
// ----------------------------------------------------------------------------
`ifndef WRITEBACK_SLOT_NOP_INSERTER_DEFINES_SVH
`define WRITEBACK_SLOT_NOP_INSERTER_DEFINES_SVH

// same-cycle implication
`define WSNI_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wsni check failed");

// next-cycle implication
`define WSNI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wsni check failed");

`endif

// ===== rtl/wsni_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsni_pkg
// shared widths, codes and control types of the writeback slot nop inserter
// ----------------------------------------------------------------------------
package wsni_pkg;

  localparam int WORD_W    = 32;
  localparam int LAT_W     = 4;
  localparam int KIND_W    = 2;
  localparam int CNT_W     = 4;
  localparam int CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NOP_WORD      = 1'b1;

  // instruction kinds; the unused code behaves as no writeback
  typedef enum logic [KIND_W-1:0] {
    KIND_NORMAL = 2'd0,
    KIND_NO_WB  = 2'd1,
    KIND_STOP   = 2'd2
  } kind_e;

  // per-cycle window update
  typedef struct packed {
    logic advance;  // shift the window by the channel count
    logic reserve;  // mark the slots of the current instruction
  } win_ctrl_t;

endpackage

// ===== rtl/wsni_item_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsni_item_if
// instruction beat channel: word, latency and kind with valid/ready
// ----------------------------------------------------------------------------
interface wsni_item_if;
  import wsni_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] instr_word;
  logic [LAT_W-1:0]  latency;
  logic [KIND_W-1:0] kind;

  modport source (output valid, instr_word, latency, kind, input ready);
  modport sink   (input valid, instr_word, latency, kind, output ready);
endinterface

// ===== rtl/wsni_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsni_result_if
// emitted word channel: word, nop flag and last flag with valid/ready
// ----------------------------------------------------------------------------
interface wsni_result_if;
  import wsni_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] out_word;
  logic              inserted;
  logic              last;

  modport source (output valid, out_word, inserted, last, input ready);
  modport sink   (input valid, out_word, inserted, last, output ready);
endinterface

// ===== rtl/writeback_slot_nop_inserter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// writeback_slot_nop_inserter
// inserts nop words so that each instruction's writeback slots are free
// ----------------------------------------------------------------------------
// Each instruction beat produces its inserted nops followed by the instruction
// itself (flagged last); up to a stop instruction, the slot window is checked
// and shifted once per emitted word, except for the stop word itself. For an
// instruction needing no nop, the next beat is taken in the same cycle its
// result is registered. A single registered output stage holds one result;
// while it waits for the sink the current beat cannot step, so while a beat
// is held the input stays not ready until the output stage drains.
// After a stop instruction, checking is off until reset.
// Configuration writes are only safe while no beat is in flight.
// ----------------------------------------------------------------------------
module writeback_slot_nop_inserter import wsni_pkg::*; #(
  parameter int MAX_LATENCY  = 15,
  parameter int MAX_CHANNELS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [WORD_W-1:0]    cfg_data_i,
  wsni_item_if.sink            item_i,
  wsni_result_if.source        result_o
);

`include "writeback_slot_nop_inserter_defines.svh"

  localparam int WIN = MAX_LATENCY + MAX_CHANNELS;
  localparam int SW  = $clog2(WIN + 1);
  localparam int CFW = (SW > CNT_W) ? SW : CNT_W;
  localparam int LFW = (SW > LAT_W) ? SW : LAT_W;
  localparam int NW  = $clog2(MAX_LATENCY + 2);

  // configuration
  logic [CNT_W-1:0]  channel_count_q;
  logic [WORD_W-1:0] nop_word_q;

  // item being worked on
  logic              busy_q;
  logic [WORD_W-1:0] word_q;
  logic [LAT_W-1:0]  lat_q;
  logic [KIND_W-1:0] kind_q;
  logic [NW-1:0]     nop_cnt_q;
  logic              stopped_q;

  // output stage
  logic              out_valid_q;
  logic [WORD_W-1:0] out_word_q;
  logic              out_ins_q;
  logic              out_last_q;

  logic              in_beat;
  logic              out_free;
  logic              step;
  logic              is_nop;
  logic              finish;
  logic              conflict;
  logic [CFW-1:0]    cnt_ext;
  logic [LFW-1:0]    lat_ext;
  logic [SW-1:0]     ch_eff;
  logic [SW-1:0]     lat_eff;
  win_ctrl_t         win_ctrl;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_count_q <= CNT_W'(1);
      nop_word_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CHANNEL_COUNT: channel_count_q <= cfg_data_i[CNT_W-1:0];
        REG_NOP_WORD:      nop_word_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamp channel count and latency to the window bounds
  assign cnt_ext = CFW'(channel_count_q);
  assign lat_ext = LFW'(lat_q);
  assign ch_eff  = (cnt_ext > CFW'(MAX_CHANNELS)) ? SW'(MAX_CHANNELS) : SW'(cnt_ext);
  assign lat_eff = (lat_ext > LFW'(MAX_LATENCY))  ? SW'(MAX_LATENCY)  : SW'(lat_ext);

  // step decision
  assign out_free = !out_valid_q || result_o.ready;
  assign step     = busy_q && out_free;
  assign is_nop   = !stopped_q && (kind_q == KIND_NORMAL) && conflict
                    && (nop_cnt_q < NW'(MAX_LATENCY + 1));
  assign finish   = step && !is_nop;

  assign win_ctrl.advance = step && !stopped_q && (is_nop || (kind_q != KIND_STOP));
  assign win_ctrl.reserve = finish && !stopped_q && (kind_q == KIND_NORMAL);

  assign item_i.ready = !busy_q || finish;
  assign in_beat      = item_i.valid && item_i.ready;

  wsni_window #(
    .WIN    (WIN),
    .SW     (SW),
    .MAX_CH (MAX_CHANNELS)
  ) u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (win_ctrl),
    .lat_i      (lat_eff),
    .ch_i       (ch_eff),
    .conflict_o (conflict)
  );

  // item control and stop flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      nop_cnt_q <= '0;
      stopped_q <= 1'b0;
    end else begin
      if (in_beat) begin
        busy_q    <= 1'b1;
        nop_cnt_q <= '0;
      end else if (finish) begin
        busy_q <= 1'b0;
      end else if (step) begin
        nop_cnt_q <= nop_cnt_q + 1'b1;
      end
      if (finish && (kind_q == KIND_STOP)) begin
        stopped_q <= 1'b1;
      end
    end
  end

  // item payload
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      word_q <= item_i.instr_word;
      lat_q  <= item_i.latency;
      kind_q <= item_i.kind;
    end
  end

  // output stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output stage payload
  always_ff @(posedge clk_i) begin
    if (step) begin
      out_word_q <= is_nop ? nop_word_q : word_q;
      out_ins_q  <= is_nop;
      out_last_q <= !is_nop;
    end
  end

  assign result_o.valid    = out_valid_q;
  assign result_o.out_word = out_word_q;
  assign result_o.inserted = out_ins_q;
  assign result_o.last     = out_last_q;

  // checks
  `WSNI_ASSERT_NOW(a_stop_no_nop, clk_i, rst_ni, step && stopped_q, finish)
  `WSNI_ASSERT_NOW(a_hold_input, clk_i, rst_ni, busy_q && !finish, !item_i.ready)
  `WSNI_ASSERT_NEXT(a_step_loads, clk_i, rst_ni, step, out_valid_q && (out_ins_q != out_last_q))
  `WSNI_ASSERT_NOW(a_nop_cap, clk_i, rst_ni, busy_q, nop_cnt_q <= NW'(MAX_LATENCY + 1))

endmodule

// ===== rtl/wsni_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsni_cell
// one writeback slot flag; checks its own slot against the request range,
// marks it on reserve and takes its neighbour's flag on advance
// ----------------------------------------------------------------------------
module wsni_cell import wsni_pkg::*; #(
  parameter int IDX    = 0,
  parameter int SW     = 5,
  parameter int MAX_CH = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  win_ctrl_t         ctrl_i,
  input  logic [SW-1:0]     lat_i,
  input  logic [SW-1:0]     ch_i,
  input  logic [MAX_CH-1:0] ahead_i,   // merged flags of the next cells up
  output logic              merged_o,  // own flag with this beat's reservation
  output logic              conflict_o
);

  localparam logic [SW-1:0] IDX_V = SW'(IDX);

  logic slot_q, slot_d;
  logic in_range;
  logic shifted;

  // slot lies inside [lat, lat + ch)
  assign in_range   = (IDX_V >= lat_i) && (IDX_V < (lat_i + ch_i));
  assign conflict_o = slot_q & in_range;
  assign merged_o   = slot_q | (ctrl_i.reserve & in_range);

  // pick the neighbour flag ch slots ahead
  always_comb begin
    shifted = merged_o;
    for (int j = 0; j < MAX_CH; j++) begin
      if (ch_i == SW'(j + 1)) shifted = ahead_i[j];
    end
  end

  always_comb begin
    if (ctrl_i.advance) begin
      slot_d = shifted;
    end else begin
      slot_d = merged_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= 1'b0;
    end else begin
      slot_q <= slot_d;
    end
  end

endmodule

// ===== rtl/wsni_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsni_window
// row of slot cells covering the writeback window ahead of the issue slot
// ----------------------------------------------------------------------------
module wsni_window import wsni_pkg::*; #(
  parameter int WIN    = 23,
  parameter int SW     = 5,
  parameter int MAX_CH = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  win_ctrl_t     ctrl_i,
  input  logic [SW-1:0] lat_i,
  input  logic [SW-1:0] ch_i,
  output logic          conflict_o
);

  logic [WIN-1:0] merged;
  logic [WIN-1:0] conflict_vec;

  for (genvar k = 0; k < WIN; k++) begin : g_slot
    logic [MAX_CH-1:0] ahead;

    // neighbour flags, zero past the end of the window
    for (genvar j = 0; j < MAX_CH; j++) begin : g_ahead
      if (k + 1 + j < WIN) begin : g_in
        assign ahead[j] = merged[k+1+j];
      end else begin : g_out
        assign ahead[j] = 1'b0;
      end
    end

    wsni_cell #(
      .IDX    (k),
      .SW     (SW),
      .MAX_CH (MAX_CH)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl_i),
      .lat_i      (lat_i),
      .ch_i       (ch_i),
      .ahead_i    (ahead),
      .merged_o   (merged[k]),
      .conflict_o (conflict_vec[k])
    );
  end

  // any requested slot already taken
  assign conflict_o = |conflict_vec;

endmodule
